### rtl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// Word types and opcodes shared by the versioned snapshot array.
// ----------------------------------------------------------------------------
`default_nettype none

package vsa_pkg;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SNAP  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [5:0]         entry_index;
		logic signed [31:0] write_value;
		logic [15:0]        query_snap;
	} cmd_word_t;

	typedef struct packed {
		logic [15:0]        snap_number;
		logic signed [31:0] read_value;
		logic               status;
	} rsp_word_t;

endpackage

`default_nettype wire

### rtl/vsa_ram.sv
// ----------------------------------------------------------------------------
// vsa_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/versioned_snapshot_array.sv
// ----------------------------------------------------------------------------
// versioned_snapshot_array
// Array of entries, each with a short history of (snapshot, value) records.
// ----------------------------------------------------------------------------
// One word is taken at a time; cmd_stall stays high until its result has
// been loaded into the response register. A snap or no-op goes straight
// to the finish state; a write reads the record count, then the last
// record if the history is not empty; a read reads the count, then makes
// binary-search probes, at most clog2(HISTORY_DEPTH)+1 (5 for a 16-record
// history). The single read port of the record memory sets the probe rate.
// A clearing pass after reset zeroes every record count before a word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module versioned_snapshot_array #(
	parameter int ENTRIES       = 64,
	parameter int HISTORY_DEPTH = 16,
	parameter int VALUE_WIDTH   = 32,
	parameter int SNAP_WIDTH    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  vsa_pkg::cmd_word_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output vsa_pkg::rsp_word_t rsp
);

	import vsa_pkg::*;

	localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW    = $clog2(HISTORY_DEPTH + 1);
	localparam int DEPTH = ENTRIES * HISTORY_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = SNAP_WIDTH + VALUE_WIDTH;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CNT   = 3'd2;
	localparam logic [2:0] ST_WLAST = 3'd3;
	localparam logic [2:0] ST_PROBE = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]             state_q, state_d;
	logic [EW-1:0]          clr_q;
	logic [SNAP_WIDTH-1:0]  ctr_q, ctr_d;
	logic                   rsp_valid_q;
	rsp_word_t              rsp_q;
	rsp_word_t              res_q, res_d;

	logic [1:0]             op_q;
	logic [EW-1:0]          entry_q;
	logic [AW-1:0]          base_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [SNAP_WIDTH-1:0]  query_q;
	logic [CW-1:0]          n_q, n_d;
	logic [CW-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [VALUE_WIDTH-1:0] found_q, found_d;

	logic                   load;
	logic                   rsp_load;
	logic [31:0]            idx32;
	logic [EW-1:0]          idx;
	logic                   idx_ok;
	logic [63:0]            val64, qry64, ctr64, fnd64;

	logic                   cnt_we, cnt_re;
	logic [EW-1:0]          cnt_waddr, cnt_raddr;
	logic [CW-1:0]          cnt_wdata, cnt_rdata;
	logic                   rec_we, rec_re;
	logic [AW-1:0]          rec_waddr, rec_raddr;
	logic [RW-1:0]          rec_wdata, rec_rdata;
	logic [SNAP_WIDTH-1:0]  rec_snap;
	logic [VALUE_WIDTH-1:0] rec_value;
	logic                   hit;

	assign idx32     = 32'(cmd.entry_index);
	assign idx       = idx32[EW-1:0];
	assign idx_ok    = idx32 < 32'(ENTRIES);
	assign val64     = {32'd0, cmd.write_value};
	assign qry64     = {48'd0, cmd.query_snap};
	assign ctr64     = 64'(ctr_q);
	assign rec_snap  = rec_rdata[RW-1:VALUE_WIDTH];
	assign rec_value = rec_rdata[VALUE_WIDTH-1:0];
	assign hit       = rec_snap <= query_q;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cnt_re    = load;
	assign cnt_raddr = idx;

	always_comb begin
		state_d   = state_q;
		ctr_d     = ctr_q;
		res_d     = res_q;
		n_d       = n_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		found_d   = found_q;
		load      = 1'b0;
		rsp_load  = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = entry_q;
		cnt_wdata = '0;
		rec_we    = 1'b0;
		rec_waddr = base_q;
		rec_wdata = {ctr_q, val_q};
		rec_re    = 1'b0;
		rec_raddr = base_q;
		fnd64     = '0;
		unique case (state_q)
			ST_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				if (clr_q == EW'(ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					load    = 1'b1;
					res_d   = '0;
					state_d = ST_FIN;
					unique case (cmd.opcode) inside
						OP_WRITE, OP_READ: begin
							if (idx_ok) begin
								state_d = ST_CNT;
							end
						end
						OP_SNAP: begin
							res_d.snap_number = ctr64[15:0];
							if (ctr_q == '1) begin
								res_d.status = 1'b1;
							end else begin
								ctr_d = ctr_q + 1'b1;
							end
						end
						default: begin
							state_d = ST_FIN;
						end
					endcase
				end
			end
			ST_CNT: begin
				n_d = cnt_rdata;
				if (op_q == OP_WRITE) begin
					if (cnt_rdata != '0) begin
						rec_re    = 1'b1;
						rec_raddr = base_q + AW'(cnt_rdata - 1'b1);
						state_d   = ST_WLAST;
					end else begin
						rec_we    = 1'b1;
						cnt_we    = 1'b1;
						cnt_wdata = CW'(1);
						state_d   = ST_FIN;
					end
				end else begin
					found_d = '0;
					lo_d    = '0;
					hi_d    = cnt_rdata;
					mid_d   = cnt_rdata >> 1;
					if (cnt_rdata != '0) begin
						rec_re    = 1'b1;
						rec_raddr = base_q + AW'(cnt_rdata >> 1);
						state_d   = ST_PROBE;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_WLAST: begin
				state_d = ST_FIN;
				if (rec_snap == ctr_q) begin
					rec_we    = 1'b1;
					rec_waddr = base_q + AW'(n_q - 1'b1);
				end else if (n_q >= CW'(HISTORY_DEPTH)) begin
					res_d.status = 1'b1;
				end else begin
					rec_we    = 1'b1;
					rec_waddr = base_q + AW'(n_q);
					cnt_we    = 1'b1;
					cnt_wdata = n_q + 1'b1;
				end
			end
			ST_PROBE: begin
				if (hit) begin
					found_d = rec_value;
					lo_d    = mid_q + 1'b1;
				end else begin
					hi_d = mid_q;
				end
				mid_d = lo_d + ((hi_d - lo_d) >> 1);
				if (lo_d < hi_d) begin
					rec_re    = 1'b1;
					rec_raddr = base_q + AW'(mid_d);
				end else begin
					fnd64            = 64'(found_d);
					res_d.read_value = fnd64[31:0];
					state_d          = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			ctr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ctr_q   <= ctr_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q   <= res_d;
		n_q     <= n_d;
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		found_q <= found_d;
		if (load) begin
			op_q    <= cmd.opcode;
			entry_q <= idx;
			base_q  <= AW'(idx) * AW'(HISTORY_DEPTH);
			val_q   <= val64[VALUE_WIDTH-1:0];
			query_q <= qry64[SNAP_WIDTH-1:0];
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	vsa_ram #(
		.WIDTH (CW),
		.DEPTH (ENTRIES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	vsa_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_record_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside the finish state");

	a_probe_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (lo_q < hi_q))
		else $error("search probe with an empty window");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wdata <= CW'(HISTORY_DEPTH)))
		else $error("record count above history depth");

	a_ctr_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (ctr_q >= $past(ctr_q)))
		else $error("snapshot counter went backward");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the versioned snapshot array.
// Commands are driven against a behavioral copy of the entry histories and
// snapshot counter. Each response word is checked field by field in order.
// A short directed sweep runs first, then a history fill on one entry, then
// random traffic under three idle mixes with one long receiver hold.
// The run ends with a few snaps, writes and reads and a short random tail.
// ----------------------------------------------------------------------------

module tb;

	import vsa_pkg::*;

	localparam int  N_ENTRIES    = 64;
	localparam int  N_HIST       = 16;
	localparam int  RAND_WORDS   = 430;
	localparam int  HOLD_CYCLES  = 300;
	localparam int  DRAIN_CYCLES = 50;
	localparam int  CYCLE_LIMIT  = 2000000;
	localparam logic ST_OK       = 1'b0;
	localparam logic ST_REJECT   = 1'b1;

	typedef struct packed {
		cmd_word_t w;
		logic      typed;
		rsp_word_t r;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_word_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	logic [15:0]        hist_snap  [N_ENTRIES][N_HIST];
	logic signed [31:0] hist_value [N_ENTRIES][N_HIST];
	int                 hist_count [N_ENTRIES];
	logic [15:0]        snap_ctr;

	rsp_word_t  pending_rsp_q [$];
	stim_row_t  dir_rows [$];
	rsp_word_t  want_rsp;
	int         cmd_idle_pct  = 26;
	int         rsp_stall_pct = 76;
	bit         hold_req      = 1'b0;
	int         err_count     = 0;
	int         n_sent        = 0;
	int         n_checked     = 0;
	int         n_dropped     = 0;
	int         n_saturated   = 0;
	int         cycle_count   = 0;

	versioned_snapshot_array i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words pending", cycle_count,
				pending_rsp_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %0h expected %0h", $time, what, got, want);
		err_count++;
	endtask

	function automatic rsp_word_t compute_snapshot_rsp(input cmd_word_t w);
		rsp_word_t r;
		int n;
		int lo;
		int hi;
		int mid;
		r = '0;
		r.status = ST_OK;
		case (w.opcode)
			OP_WRITE: begin
				n = hist_count[w.entry_index];
				if (n > 0 && hist_snap[w.entry_index][n-1] == snap_ctr) begin
					hist_value[w.entry_index][n-1] = w.write_value;
				end else if (n >= N_HIST) begin
					r.status = ST_REJECT;
				end else begin
					hist_snap[w.entry_index][n]  = snap_ctr;
					hist_value[w.entry_index][n] = w.write_value;
					hist_count[w.entry_index]    = n + 1;
				end
			end
			OP_SNAP: begin
				r.snap_number = snap_ctr;
				if (snap_ctr == 16'hFFFF)
					r.status = ST_REJECT;
				else
					snap_ctr = snap_ctr + 16'd1;
			end
			OP_READ: begin
				lo = 0;
				hi = hist_count[w.entry_index];
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (hist_snap[w.entry_index][mid] <= w.query_snap) begin
						r.read_value = hist_value[w.entry_index][mid];
						lo = mid + 1;
					end else begin
						hi = mid;
					end
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	task automatic send_word(input cmd_word_t w, input logic typed, input rsp_word_t typed_rsp);
		int gap;
		rsp_word_t pred;
		gap = 0;
		while ($urandom_range(99) < cmd_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pred = compute_snapshot_rsp(w);
		pending_rsp_q.push_back(typed ? typed_rsp : pred);
		n_sent++;
		if (pred.status == ST_REJECT) begin
			if (w.opcode == OP_WRITE)
				n_dropped++;
			else
				n_saturated++;
		end
	endtask

	function automatic cmd_word_t mk_cmd(input logic [1:0] op, input logic [5:0] e,
		input logic [31:0] v, input logic [15:0] q);
		cmd_word_t w;
		w.opcode      = op;
		w.entry_index = e;
		w.write_value = v;
		w.query_snap  = q;
		return w;
	endfunction

	function automatic stim_row_t mk_row(input logic [1:0] op, input logic [5:0] e,
		input logic [31:0] v, input logic [15:0] q, input logic typed,
		input logic [15:0] xs, input logic [31:0] xv, input logic xst);
		stim_row_t row;
		row.w             = mk_cmd(op, e, v, q);
		row.typed         = typed;
		row.r.snap_number = xs;
		row.r.read_value  = xv;
		row.r.status      = xst;
		return row;
	endfunction

	function automatic cmd_word_t random_cmd(input int hot_base);
		cmd_word_t w;
		int pick;
		int lim;
		pick = $urandom_range(99);
		w.opcode = (pick < 40) ? OP_WRITE : (pick < 55) ? OP_SNAP :
			(pick < 95) ? OP_READ : OP_NOP;
		if ($urandom_range(99) < 75)
			w.entry_index = 6'(hot_base + $urandom_range(3));
		else
			w.entry_index = 6'($urandom_range(N_ENTRIES - 1));
		case ($urandom_range(19))
			0:       w.write_value = 32'h7FFFFFFF;
			1:       w.write_value = 32'h80000000;
			2:       w.write_value = 32'hFFFFFFFF;
			default: w.write_value = $urandom;
		endcase
		lim = int'(snap_ctr) + 1;
		if (lim > 65535)
			lim = 65535;
		if ($urandom_range(99) < 70)
			w.query_snap = 16'($urandom_range(lim));
		else
			w.query_snap = 16'($urandom_range(65535));
		return w;
	endfunction

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				report_mismatch("word with nothing pending", 64'(rsp), 64'd0);
			end else begin
				want_rsp = pending_rsp_q.pop_front();
				if (rsp.snap_number !== want_rsp.snap_number)
					report_mismatch("snap_number", 64'(rsp.snap_number),
						64'(want_rsp.snap_number));
				if (rsp.read_value !== want_rsp.read_value)
					report_mismatch("read_value", 64'(unsigned'(rsp.read_value)),
						64'(unsigned'(want_rsp.read_value)));
				if (rsp.status !== want_rsp.status)
					report_mismatch("status", 64'(rsp.status), 64'(want_rsp.status));
				n_checked++;
			end
		end
	end

	initial begin
		for (int e = 0; e < N_ENTRIES; e++)
			hist_count[e] = 0;
		snap_ctr = '0;

		dir_rows.push_back(mk_row(OP_READ,  6'd0,  32'h0,        16'h0,    1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd63, 32'h0,        16'hFFFF, 1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_SNAP,  6'd0,  32'h0,        16'h0,    1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_WRITE, 6'd0,  32'h7FFFFFFF, 16'h0,    1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_WRITE, 6'd63, 32'h80000000, 16'h0,    1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd0,  32'h0,        16'h0,    0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd0,  32'h0,        16'h1,    1, 16'd0,
			32'h7FFFFFFF, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd63, 32'h0,        16'hFFFF, 1, 16'd0,
			32'h80000000, ST_OK));
		dir_rows.push_back(mk_row(OP_WRITE, 6'd0,  32'd5,        16'h0,    1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd0,  32'h0,        16'h1,    0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_NOP,   6'd0,  32'h0,        16'h0,    1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_NOP,   6'd63, 32'hFFFFFFFF, 16'hFFFF, 1, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_SNAP,  6'd63, 32'hFFFFFFFF, 16'hFFFF, 1, 16'd1, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_WRITE, 6'd0,  32'hFFFFFFFF, 16'h0,    0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd0,  32'h0,        16'hFFFF, 0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd0,  32'h0,        16'h1,    0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_WRITE, 6'd21, 32'h55555555, 16'h0,    0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_WRITE, 6'd42, 32'hAAAAAAAA, 16'h0,    0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd21, 32'h0,        16'hAAAA, 0, 16'd0, 32'h0, ST_OK));
		dir_rows.push_back(mk_row(OP_READ,  6'd42, 32'h0,        16'h5555, 0, 16'd0, 32'h0, ST_OK));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

		// fill one history, rewrite at full, then overflow it
		for (int k = 0; k < N_HIST; k++) begin
			send_word(mk_cmd(OP_WRITE, 6'd9, $urandom, 16'h0), 0, '0);
			if (k < N_HIST - 1)
				send_word(mk_cmd(OP_SNAP, 6'd9, 32'h0, 16'h0), 0, '0);
		end
		send_word(mk_cmd(OP_WRITE, 6'd9, $urandom, 16'h0), 0, '0);
		send_word(mk_cmd(OP_SNAP, 6'd9, 32'h0, 16'h0), 0, '0);
		send_word(mk_cmd(OP_WRITE, 6'd9, $urandom, 16'h0), 0, '0);
		for (int q = 0; q <= int'(snap_ctr); q++)
			send_word(mk_cmd(OP_READ, 6'd9, 32'h0, 16'(q)), 0, '0);

		for (int ph = 0; ph < 3; ph++) begin
			cmd_idle_pct  = (ph == 0) ? 26 : (ph == 1) ? 76 : 0;
			rsp_stall_pct = (ph == 0) ? 76 : (ph == 1) ? 26 : 0;
			if (ph == 2)
				hold_req = 1'b1;
			for (int n = 0; n < RAND_WORDS; n++)
				send_word(random_cmd(ph * 8 + 12), 0, '0);
		end

		send_word(mk_cmd(OP_SNAP, 6'd0, 32'h0, 16'h0), 0, '0);
		send_word(mk_cmd(OP_SNAP, 6'd63, 32'hFFFFFFFF, 16'hFFFF), 0, '0);
		send_word(mk_cmd(OP_WRITE, 6'd40, $urandom, 16'h0), 0, '0);
		send_word(mk_cmd(OP_WRITE, 6'd40, $urandom, 16'h0), 0, '0);
		send_word(mk_cmd(OP_READ, 6'd40, 32'h0, 16'hFFFF), 0, '0);
		send_word(mk_cmd(OP_READ, 6'd40, 32'h0, 16'hFFFE), 0, '0);
		for (int n = 0; n < 20; n++)
			send_word(random_cmd(0), 0, '0);
		cmd_valid <= 1'b0;

		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d words, checked %0d responses, %0d writes dropped on full history",
			n_sent, n_checked, n_dropped);
		$display("%0d snaps hit the saturated counter, %0d mismatches", n_saturated, err_count);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
